/* src/so3_pkg.sv */
// shared types, constants and fixed-point helpers for the so3 exponential map
`timescale 1ns / 1ps

package so3_pkg;

    // fixed-point formats
    localparam int IN_FRAC_BITS  = 24;
    localparam int OUT_FRAC_BITS = 30;

    // pipeline depths of the iterative units
    localparam int SQRT_STAGES  = 32;
    localparam int DIV_STAGES   = 31;
    localparam int HORNER_STEPS = 5;
    localparam int SC_STAGES    = HORNER_STEPS + 4;
    localparam int SC_PAD       = DIV_STAGES - SC_STAGES;

    // phase and angle constants
    localparam logic [29:0] TURN_SCALE = 30'd683565276;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;

    typedef logic signed [33:0] q30_t;
    typedef logic signed [47:0] wide_t;
    typedef logic signed [31:0] word_t;
    typedef logic [2:0][31:0]   vec_t;
    typedef logic [8:0][31:0]   mat_t;

    localparam q30_t ONE_Q30 = 34'sd1073741824;

    // quadrant codes of the phase
    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    // sine and cosine series coefficients, highest order first
    localparam q30_t SIN_TOP = -34'sd27;
    localparam q30_t COS_TOP = 34'sd2;
    localparam q30_t SIN_C [HORNER_STEPS] = '{
        34'sd2959, -34'sd213044, 34'sd8947849, -34'sd178956971, 34'sd1073741824
    };
    localparam q30_t COS_C [HORNER_STEPS] = '{
        -34'sd296, 34'sd26631, -34'sd1491308, 34'sd44739243, -34'sd536870912
    };

    // output rescaling shifts
    localparam int IN_SH_L = (OUT_FRAC_BITS >= IN_FRAC_BITS) ? OUT_FRAC_BITS - IN_FRAC_BITS : 0;
    localparam int IN_SH_R = (OUT_FRAC_BITS >= IN_FRAC_BITS) ? 0 : IN_FRAC_BITS - OUT_FRAC_BITS;
    localparam int Q_SH_R  = 30 - OUT_FRAC_BITS;

    localparam wide_t ONE_OUT = 48'sd1 <<< OUT_FRAC_BITS;

    // magnitude of a 32-bit signed word
    function automatic logic [31:0] mag32(logic [31:0] v);
        return v[31] ? 32'(-v) : v;
    endfunction

    // q30 product, rounded half away from zero
    function automatic q30_t mulq(q30_t a, q30_t b);
        logic [32:0] ma;
        logic [32:0] mb;
        logic [65:0] pr;
        q30_t        m;
        ma = a[33] ? 33'(-a) : 33'(a);
        mb = b[33] ? 33'(-b) : 33'(b);
        pr = 66'(ma) * 66'(mb);
        pr = pr + (66'd1 << 29);
        m  = q30_t'({1'b0, pr[62:30]});
        return (a[33] != b[33]) ? -m : m;
    endfunction

    // shift a signed value with rounding of the magnitude half away from zero
    function automatic wide_t round_shift(wide_t v, int sh_l, int sh_r);
        logic [47:0] m;
        m = v[47] ? 48'(-v) : 48'(v);
        m = ((m << sh_l) + ((48'd1 << sh_r) >> 1)) >> sh_r;
        return v[47] ? -$signed(m) : $signed(m);
    endfunction

    // clamp to plus or minus one in the output format
    function automatic logic [31:0] sat_out(wide_t v);
        wide_t c;
        c = v;
        if (v > ONE_OUT) begin
            c = ONE_OUT;
        end
        if (v < -ONE_OUT) begin
            c = -ONE_OUT;
        end
        return c[31:0];
    endfunction

endpackage

/* src/so3_in_if.sv */
// input channel carrying one rotation vector per transaction
`timescale 1ns / 1ps

interface so3_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] omega_x;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_z;

    modport source (output valid, output omega_x, output omega_y, output omega_z,
                    input ready);
    modport sink   (input valid, input omega_x, input omega_y, input omega_z,
                    output ready);
endinterface

/* src/so3_out_if.sv */
// output channel carrying one rotation matrix per transaction
`timescale 1ns / 1ps

interface so3_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] r00;
    logic signed [31:0] r01;
    logic signed [31:0] r02;
    logic signed [31:0] r10;
    logic signed [31:0] r11;
    logic signed [31:0] r12;
    logic signed [31:0] r20;
    logic signed [31:0] r21;
    logic signed [31:0] r22;

    modport source (output valid, output r00, output r01, output r02, output r10,
                    output r11, output r12, output r20, output r21, output r22,
                    input ready);
    modport sink   (input valid, input r00, input r01, input r02, input r10,
                    input r11, input r12, input r20, input r21, input r22,
                    output ready);
endinterface

/* src/so3_cfg_if.sv */
// configuration write channel for the small-angle limit
`timescale 1ns / 1ps

interface so3_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] small_angle_limit;

    modport source (output valid, output small_angle_limit, input ready);
    modport sink   (input valid, input small_angle_limit, output ready);
endinterface

/* src/so3_exp_map_top.sv */
// top level of the so3 exponential map pipeline
//
// Usage: a rotation vector (omega_x, omega_y, omega_z, signed with
// IN_FRAC_BITS fraction bits) enters on the vec channel; the rotation
// matrix r00..r22, row-major, saturated to plus or minus one with
// OUT_FRAC_BITS fraction bits, leaves on the mat channel. The cfg channel
// writes the small-angle limit; it is always ready and is to be written
// only while no transaction is in flight.
// The 32-stage square root is followed by the 31-stage dividers for the
// unit axis; sine and cosine run alongside the dividers. Throughput is
// one vector per cycle while the output queue is not full.
// Reset clears all valid bits, the output queue and sets the small-angle
// limit to 1; payload registers are not reset.
// A two-entry output queue takes finished matrices. When the receiver
// stalls and the queue fills, the whole pipeline holds and vec.ready
// drops; nothing is lost or repeated, and input resumes as soon as one
// queued matrix is taken.
`timescale 1ns / 1ps

module so3_exp_map_top (
    input  logic        clk,
    input  logic        rst_n,
    so3_in_if.sink      vec,
    so3_out_if.source   mat,
    so3_cfg_if.sink     cfg
);
    localparam int NS  = so3_pkg::SQRT_STAGES;
    localparam int ND  = so3_pkg::DIV_STAGES;
    localparam int NP  = so3_pkg::SC_PAD;

    logic en;
    logic push;
    logic pop;

    // configuration register
    logic [15:0] limit_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= 16'd1;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.small_angle_limit;
        end
    end

    // valid bits of all stages
    logic          a_vld_reg;
    logic          b_vld_reg;
    logic          c_vld_reg;
    logic [NS-1:0] sq_vld_reg;
    logic          d_vld_reg;
    logic [ND-1:0] dv_vld_reg;
    logic          k1_vld_reg;
    logic          k2_vld_reg;
    logic          k3_vld_reg;

    assign vec.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
            sq_vld_reg <= '0;
            d_vld_reg  <= 1'b0;
            dv_vld_reg <= '0;
            k1_vld_reg <= 1'b0;
            k2_vld_reg <= 1'b0;
            k3_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg  <= vec.valid;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
            sq_vld_reg <= {sq_vld_reg[NS-2:0], c_vld_reg};
            d_vld_reg  <= sq_vld_reg[NS-1];
            dv_vld_reg <= {dv_vld_reg[ND-2:0], d_vld_reg};
            k1_vld_reg <= dv_vld_reg[ND-1];
            k2_vld_reg <= k1_vld_reg;
            k3_vld_reg <= k2_vld_reg;
        end
    end

    // input register, squares and sum of squares
    so3_pkg::vec_t a_w_reg;
    so3_pkg::vec_t b_w_reg;
    so3_pkg::vec_t c_w_reg;
    logic [63:0]   b_sq_reg [3];
    logic [63:0]   c_t2_reg;
    logic [63:0]   b_sq_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            b_sq_next[i] = 64'(so3_pkg::mag32(a_w_reg[i])) * 64'(so3_pkg::mag32(a_w_reg[i]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_w_reg  <= {vec.omega_z, vec.omega_y, vec.omega_x};
            b_w_reg  <= a_w_reg;
            b_sq_reg <= b_sq_next;
            c_w_reg  <= b_w_reg;
            c_t2_reg <= b_sq_reg[0] + b_sq_reg[1] + b_sq_reg[2];
        end
    end

    // angle magnitude
    logic [31:0]   root;
    so3_pkg::vec_t sq_w_reg [NS];

    so3_sqrt u_sqrt (
        .clk  (clk),
        .en   (en),
        .rad  (c_t2_reg),
        .root (root)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_w_reg[0] <= c_w_reg;
            for (int s = 1; s < NS; s++)
            begin
                sq_w_reg[s] <= sq_w_reg[s-1];
            end
        end
    end

    // small-angle test, phase product and divider numerators
    logic          d_small_next;
    logic [61:0]   d_prod_next;
    logic [61:0]   d_num_next [3];
    logic          d_small_reg;
    logic [61:0]   d_prod_reg;
    logic [61:0]   d_num_reg  [3];
    logic [31:0]   d_t_reg;
    so3_pkg::vec_t d_w_reg;

    always_comb
    begin
        d_small_next = (root == 32'd0) || (root < {16'd0, limit_reg});
        d_prod_next  = 62'(root) * 62'(so3_pkg::TURN_SCALE);
        for (int i = 0; i < 3; i++)
        begin
            d_num_next[i] = {so3_pkg::mag32(sq_w_reg[NS-1][i]), 30'd0} + 62'(root >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_small_reg <= d_small_next;
            d_prod_reg  <= d_prod_next;
            d_num_reg   <= d_num_next;
            d_t_reg     <= root;
            d_w_reg     <= sq_w_reg[NS-1];
        end
    end

    // unit axis dividers
    logic [30:0] quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        so3_div u_div (
            .clk (clk),
            .en  (en),
            .num (d_num_reg[i]),
            .den (d_t_reg),
            .quo (quo[i])
        );
    end

    // sine and cosine, padded to the divider latency
    logic [31:0]   phase;
    so3_pkg::q30_t sin_q;
    so3_pkg::q30_t cos_q;
    so3_pkg::q30_t pad_s_reg [NP];
    so3_pkg::q30_t pad_c_reg [NP];

    assign phase = 32'(d_prod_reg >> so3_pkg::IN_FRAC_BITS);

    so3_sincos u_sincos (
        .clk   (clk),
        .en    (en),
        .phase (phase),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    // side data along the dividers
    logic          dv_small_reg [ND];
    so3_pkg::vec_t dv_w_reg     [ND];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pad_s_reg[0]    <= sin_q;
            pad_c_reg[0]    <= cos_q;
            for (int s = 1; s < NP; s++)
            begin
                pad_s_reg[s] <= pad_s_reg[s-1];
                pad_c_reg[s] <= pad_c_reg[s-1];
            end
            dv_small_reg[0] <= d_small_reg;
            dv_w_reg[0]     <= d_w_reg;
            for (int s = 1; s < ND; s++)
            begin
                dv_small_reg[s] <= dv_small_reg[s-1];
                dv_w_reg[s]     <= dv_w_reg[s-1];
            end
        end
    end

    // axis products and sine terms
    so3_pkg::q30_t u_ax       [3];
    so3_pkg::q30_t k1_uu_next [6];
    so3_pkg::q30_t k1_su_next [3];
    so3_pkg::q30_t k1_uu_reg  [6];
    so3_pkg::q30_t k1_su_reg  [3];
    so3_pkg::q30_t k1_c_reg;
    so3_pkg::q30_t k1_omc_reg;
    logic          k1_small_reg;
    so3_pkg::vec_t k1_w_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u_ax[i] = dv_w_reg[ND-1][i][31] ? -so3_pkg::q30_t'({3'b0, quo[i]})
                                            : so3_pkg::q30_t'({3'b0, quo[i]});
            k1_uu_next[i] = so3_pkg::mulq(u_ax[i], u_ax[i]);
            k1_su_next[i] = so3_pkg::mulq(pad_s_reg[NP-1], u_ax[i]);
        end
        k1_uu_next[3] = so3_pkg::mulq(u_ax[0], u_ax[1]);
        k1_uu_next[4] = so3_pkg::mulq(u_ax[0], u_ax[2]);
        k1_uu_next[5] = so3_pkg::mulq(u_ax[1], u_ax[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_uu_reg    <= k1_uu_next;
            k1_su_reg    <= k1_su_next;
            k1_c_reg     <= pad_c_reg[NP-1];
            k1_omc_reg   <= so3_pkg::ONE_Q30 - pad_c_reg[NP-1];
            k1_small_reg <= dv_small_reg[ND-1];
            k1_w_reg     <= dv_w_reg[ND-1];
        end
    end

    // scale by one minus cosine
    so3_pkg::q30_t k2_d_next [6];
    so3_pkg::q30_t k2_d_reg  [6];
    so3_pkg::q30_t k2_su_reg [3];
    so3_pkg::q30_t k2_c_reg;
    logic          k2_small_reg;
    so3_pkg::vec_t k2_w_reg;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            k2_d_next[i] = so3_pkg::mulq(k1_omc_reg, k1_uu_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_d_reg     <= k2_d_next;
            k2_su_reg    <= k1_su_reg;
            k2_c_reg     <= k1_c_reg;
            k2_small_reg <= k1_small_reg;
            k2_w_reg     <= k1_w_reg;
        end
    end

    // matrix entries, rescale and saturate, small-angle select
    so3_pkg::q30_t  full_m [9];
    so3_pkg::wide_t skew_m [9];
    so3_pkg::mat_t  k3_m_next;
    so3_pkg::mat_t  k3_m_reg;

    always_comb
    begin
        full_m[0] = k2_c_reg + k2_d_reg[0];
        full_m[1] = k2_d_reg[3] - k2_su_reg[2];
        full_m[2] = k2_d_reg[4] + k2_su_reg[1];
        full_m[3] = k2_d_reg[3] + k2_su_reg[2];
        full_m[4] = k2_c_reg + k2_d_reg[1];
        full_m[5] = k2_d_reg[5] - k2_su_reg[0];
        full_m[6] = k2_d_reg[4] - k2_su_reg[1];
        full_m[7] = k2_d_reg[5] + k2_su_reg[0];
        full_m[8] = k2_c_reg + k2_d_reg[2];

        skew_m[0] = so3_pkg::ONE_OUT;
        skew_m[1] = -so3_pkg::wide_t'($signed(k2_w_reg[2]));
        skew_m[2] = so3_pkg::wide_t'($signed(k2_w_reg[1]));
        skew_m[3] = so3_pkg::wide_t'($signed(k2_w_reg[2]));
        skew_m[4] = so3_pkg::ONE_OUT;
        skew_m[5] = -so3_pkg::wide_t'($signed(k2_w_reg[0]));
        skew_m[6] = -so3_pkg::wide_t'($signed(k2_w_reg[1]));
        skew_m[7] = so3_pkg::wide_t'($signed(k2_w_reg[0]));
        skew_m[8] = so3_pkg::ONE_OUT;

        for (int i = 0; i < 9; i++)
        begin
            if (k2_small_reg)
            begin
                if (i == 0 || i == 4 || i == 8)
                begin
                    k3_m_next[i] = so3_pkg::sat_out(skew_m[i]);
                end
                else
                begin
                    k3_m_next[i] = so3_pkg::sat_out(so3_pkg::round_shift(skew_m[i],
                                       so3_pkg::IN_SH_L, so3_pkg::IN_SH_R));
                end
            end
            else
            begin
                k3_m_next[i] = so3_pkg::sat_out(so3_pkg::round_shift(
                                   so3_pkg::wide_t'(full_m[i]), 0, so3_pkg::Q_SH_R));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k3_m_reg <= k3_m_next;
        end
    end

    // two-entry output queue
    so3_pkg::mat_t fifo_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic [1:0]    cnt_next;

    assign en       = (cnt_reg != 2'd2);
    assign push     = en && k3_vld_reg;
    assign pop      = mat.valid && mat.ready;
    assign cnt_next = 2'(cnt_reg + {1'b0, push} - {1'b0, pop});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_reg ^ push;
            rd_ptr_reg <= rd_ptr_reg ^ pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= k3_m_reg;
        end
    end

    // output transaction
    assign mat.valid = (cnt_reg != 2'd0);
    assign mat.r00   = fifo_reg[rd_ptr_reg][0];
    assign mat.r01   = fifo_reg[rd_ptr_reg][1];
    assign mat.r02   = fifo_reg[rd_ptr_reg][2];
    assign mat.r10   = fifo_reg[rd_ptr_reg][3];
    assign mat.r11   = fifo_reg[rd_ptr_reg][4];
    assign mat.r12   = fifo_reg[rd_ptr_reg][5];
    assign mat.r20   = fifo_reg[rd_ptr_reg][6];
    assign mat.r21   = fifo_reg[rd_ptr_reg][7];
    assign mat.r22   = fifo_reg[rd_ptr_reg][8];

    // queue count never runs past two entries
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    // a full queue stops input
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2) |-> !vec.ready)
        else $error("input accepted while output queue full");

    // a held last stage keeps its matrix
    a_last_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (k3_vld_reg && !en) |=> ($stable(k3_m_reg) && k3_vld_reg))
        else $error("last stage changed during stall");

    // count rises by one on a push without a pop
    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == 2'($past(cnt_reg) + 2'd1)))
        else $error("queue count lost a push");

    // offered diagonal entries r00 and r11 stay within plus or minus one
    a_sat_diag: assert property (@(posedge clk) disable iff (!rst_n)
        mat.valid |-> ((so3_pkg::wide_t'(mat.r00) <= so3_pkg::ONE_OUT)
                    && (so3_pkg::wide_t'(mat.r00) >= -so3_pkg::ONE_OUT)
                    && (so3_pkg::wide_t'(mat.r11) <= so3_pkg::ONE_OUT)
                    && (so3_pkg::wide_t'(mat.r11) >= -so3_pkg::ONE_OUT)))
        else $error("diagonal entry outside saturation range");

endmodule

/* src/so3_sqrt.sv */
// pipelined integer square root, one root bit per stage
`timescale 1ns / 1ps

module so3_sqrt (
    input  logic        clk,
    input  logic        en,
    input  logic [63:0] rad,
    output logic [31:0] root
);
    localparam int N = so3_pkg::SQRT_STAGES;

    logic [32:0] rem_reg  [N];
    logic [31:0] root_reg [N];
    logic [63:0] rad_reg  [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [32:0] rem_in;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic [34:0] rem_next;
        logic [31:0] root_next;
        logic [63:0] rad_next;

        if (s == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end else begin : g_rest
            assign rem_in  = rem_reg[s-1];
            assign root_in = root_reg[s-1];
            assign rad_in  = rad_reg[s-1];
        end

        // bring in two radicand bits and try the next root bit
        always_comb
        begin
            rem_sh   = {rem_in, rad_in[63:62]};
            trial    = {1'b0, root_in, 2'b01};
            rad_next = {rad_in[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_next  = rem_sh - trial;
                root_next = {root_in[30:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                root_next = {root_in[30:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next[32:0];
                root_reg[s] <= root_next;
                rad_reg[s]  <= rad_next;
            end
        end
    end

    assign root = root_reg[N-1];

endmodule

/* src/so3_div.sv */
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps

module so3_div (
    input  logic        clk,
    input  logic        en,
    input  logic [61:0] num,
    input  logic [31:0] den,
    output logic [30:0] quo
);
    localparam int N = so3_pkg::DIV_STAGES;

    logic [31:0] rem_reg [N];
    logic [30:0] low_reg [N];
    logic [30:0] quo_reg [N];
    logic [31:0] den_reg [N];

    for (genvar s = 0; s < N; s++) begin : g_stage
        logic [31:0] rem_in;
        logic [30:0] low_in;
        logic [30:0] quo_in;
        logic [31:0] den_in;
        logic [32:0] rem_sh;
        logic [32:0] rem_next;
        logic [30:0] quo_next;

        // the quotient stays below 2^31, so the top bits start the remainder
        if (s == 0) begin : g_first
            assign rem_in = {1'b0, num[61:31]};
            assign low_in = num[30:0];
            assign quo_in = '0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign low_in = low_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign den_in = den_reg[s-1];
        end

        // shift in one numerator bit and subtract when it fits
        always_comb
        begin
            rem_sh = {rem_in, low_in[30]};
            if (rem_sh >= {1'b0, den_in})
            begin
                rem_next = rem_sh - {1'b0, den_in};
                quo_next = {quo_in[29:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh;
                quo_next = {quo_in[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next[31:0];
                low_reg[s] <= {low_in[29:0], 1'b0};
                quo_reg[s] <= quo_next;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quo = quo_reg[N-1];

endmodule

/* src/so3_sincos.sv */
// pipelined sine and cosine of a phase in turns, polynomial in q30
`timescale 1ns / 1ps

module so3_sincos (
    input  logic          clk,
    input  logic          en,
    input  logic [31:0]   phase,
    output so3_pkg::q30_t sin_q,
    output so3_pkg::q30_t cos_q
);
    localparam int NH = so3_pkg::HORNER_STEPS;

    typedef struct packed {
        so3_pkg::q30_t x;
        so3_pkg::q30_t x2;
        logic [1:0]    quad;
        logic          swap;
    } arg_t;

    // range reduction to an octant and scaling to radians
    logic [1:0]  quad_next;
    logic        swap_next;
    logic [29:0] red_next;
    logic [60:0] xp_next;
    logic [1:0]  quad_reg;
    logic        swap_reg;
    logic [60:0] xp_reg;

    always_comb
    begin
        quad_next = phase[31:30];
        swap_next = phase[29];
        red_next  = swap_next ? 30'((31'd1 << 30) - {1'b0, phase[29:0]}) : phase[29:0];
        xp_next   = 61'(red_next) * 61'(so3_pkg::HALFPI_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg <= quad_next;
            swap_reg <= swap_next;
            xp_reg   <= xp_next;
        end
    end

    // round the angle and square it
    logic [60:0] xr_sum;
    arg_t        arg_next;
    arg_t        arg_reg;

    always_comb
    begin
        xr_sum        = xp_reg + (61'd1 << 29);
        arg_next.x    = so3_pkg::q30_t'(xr_sum >> 30);
        arg_next.x2   = so3_pkg::mulq(arg_next.x, arg_next.x);
        arg_next.quad = quad_reg;
        arg_next.swap = swap_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_reg <= arg_next;
        end
    end

    // horner steps, sine and cosine side by side
    so3_pkg::q30_t ps_reg   [NH];
    so3_pkg::q30_t pc_reg   [NH];
    arg_t          harg_reg [NH];

    for (genvar h = 0; h < NH; h++) begin : g_horner
        so3_pkg::q30_t ps_in;
        so3_pkg::q30_t pc_in;
        arg_t          arg_in;
        so3_pkg::q30_t ps_next;
        so3_pkg::q30_t pc_next;

        if (h == 0) begin : g_first
            assign ps_in  = so3_pkg::SIN_TOP;
            assign pc_in  = so3_pkg::COS_TOP;
            assign arg_in = arg_reg;
        end else begin : g_rest
            assign ps_in  = ps_reg[h-1];
            assign pc_in  = pc_reg[h-1];
            assign arg_in = harg_reg[h-1];
        end

        always_comb
        begin
            ps_next = so3_pkg::SIN_C[h] + so3_pkg::mulq(arg_in.x2, ps_in);
            pc_next = so3_pkg::COS_C[h] + so3_pkg::mulq(arg_in.x2, pc_in);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ps_reg[h]   <= ps_next;
                pc_reg[h]   <= pc_next;
                harg_reg[h] <= arg_in;
            end
        end
    end

    // last products of the series
    so3_pkg::q30_t sa_next;
    so3_pkg::q30_t ca_next;
    so3_pkg::q30_t sa_reg;
    so3_pkg::q30_t ca_reg;
    logic [1:0]    quad2_reg;
    logic          swap2_reg;

    always_comb
    begin
        sa_next = so3_pkg::mulq(harg_reg[NH-1].x, ps_reg[NH-1]);
        ca_next = so3_pkg::ONE_Q30 + so3_pkg::mulq(harg_reg[NH-1].x2, pc_reg[NH-1]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sa_reg    <= sa_next;
            ca_reg    <= ca_next;
            quad2_reg <= harg_reg[NH-1].quad;
            swap2_reg <= harg_reg[NH-1].swap;
        end
    end

    // octant swap and quadrant signs
    so3_pkg::q30_t so_next;
    so3_pkg::q30_t co_next;
    so3_pkg::q30_t os_a;
    so3_pkg::q30_t oc_a;
    so3_pkg::q30_t so_reg;
    so3_pkg::q30_t co_reg;

    always_comb
    begin
        os_a = swap2_reg ? ca_reg : sa_reg;
        oc_a = swap2_reg ? sa_reg : ca_reg;
        case (quad2_reg)
            so3_pkg::QUAD_I:
            begin
                so_next = os_a;
                co_next = oc_a;
            end
            so3_pkg::QUAD_II:
            begin
                so_next = oc_a;
                co_next = -os_a;
            end
            so3_pkg::QUAD_III:
            begin
                so_next = -os_a;
                co_next = -oc_a;
            end
            default:
            begin
                so_next = -oc_a;
                co_next = os_a;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            so_reg <= so_next;
            co_reg <= co_next;
        end
    end

    assign sin_q = so_reg;
    assign cos_q = co_reg;

endmodule

/* tb/tb_top.sv */
// self-checking testbench for the so3 exponential map pipeline
`timescale 1ns / 1ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int RAND_PER_PHASE = 330;
    localparam int N_PHASES       = 6;
    localparam int MAX_REPORTS    = 10;

    logic clk;
    logic rst_n;

    so3_in_if  vec_if ();
    so3_out_if mat_if ();
    so3_cfg_if cfg_if ();

    so3_exp_map_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .vec   (vec_if.sink),
        .mat   (mat_if.source),
        .cfg   (cfg_if.sink)
    );

    // vectors waiting to be offered and matrices waiting to come out
    so3_pkg::vec_t pending_vecs[$];
    so3_pkg::mat_t exp_mats[$];
    int unsigned   angle_limit;
    int            n_pushed;
    int            n_accepted;
    int            err_cnt;
    int            idle_cycles;
    logic          vec_taken;
    logic          hold_off;
    int            burst_left;
    int            gap_left;
    int            stall_cnt;
    int            stall_mode;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    function automatic longint unsigned mag64(longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // q30 product rounded half away from zero
    function automatic longint fix_mul(longint a, longint b);
        longint unsigned m;
        m = (mag64(a) * mag64(b) + (64'd1 << 29)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint fix_rescale(longint v, int from_bits, int to_bits);
        longint unsigned m;
        m = mag64(v);
        if (to_bits >= from_bits)
        begin
            m = m << (to_bits - from_bits);
        end
        else
        begin
            m = (m + (64'd1 << (from_bits - to_bits - 1))) >> (from_bits - to_bits);
        end
        return (v < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint clamp_unit(longint v);
        longint lim;
        lim = longint'(1) << so3_pkg::OUT_FRAC_BITS;
        if (v > lim)
        begin
            return lim;
        end
        if (v < -lim)
        begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned n);
        longint unsigned res;
        longint unsigned bits;
        res  = 0;
        bits = 64'd1 << 62;
        while (bits > n)
        begin
            bits = bits >> 2;
        end
        while (bits != 0)
        begin
            if (n >= res + bits)
            begin
                n   = n - (res + bits);
                res = (res >> 1) + bits;
            end
            else
            begin
                res = res >> 1;
            end
            bits = bits >> 2;
        end
        return res;
    endfunction

    // sine and cosine of a phase in units of 2^-32 turn
    function automatic void phase_sincos(input longint unsigned p, output longint s,
                                         output longint c);
        logic [1:0]      quad;
        longint unsigned r;
        longint unsigned a;
        logic            swap;
        longint          x;
        longint          x2;
        longint          ps;
        longint          pc;
        longint          sa;
        longint          ca;
        longint          tmp;
        quad = p[31:30];
        r    = p & 64'h3FFFFFFF;
        swap = (r >= (64'd1 << 29));
        a    = swap ? (64'd1 << 30) - r : r;
        x    = longint'((a * so3_pkg::HALFPI_Q30 + (64'd1 << 29)) >> 30);
        x2   = fix_mul(x, x);
        ps   = -27;
        ps   = 2959 + fix_mul(x2, ps);
        ps   = -213044 + fix_mul(x2, ps);
        ps   = 8947849 + fix_mul(x2, ps);
        ps   = -178956971 + fix_mul(x2, ps);
        ps   = 1073741824 + fix_mul(x2, ps);
        sa   = fix_mul(x, ps);
        pc   = 2;
        pc   = -296 + fix_mul(x2, pc);
        pc   = 26631 + fix_mul(x2, pc);
        pc   = -1491308 + fix_mul(x2, pc);
        pc   = 44739243 + fix_mul(x2, pc);
        pc   = -536870912 + fix_mul(x2, pc);
        ca   = 1073741824 + fix_mul(x2, pc);
        if (swap)
        begin
            tmp = sa;
            sa  = ca;
            ca  = tmp;
        end
        case (quad)
            so3_pkg::QUAD_I:   begin s = sa;  c = ca;  end
            so3_pkg::QUAD_II:  begin s = ca;  c = -sa; end
            so3_pkg::QUAD_III: begin s = -sa; c = -ca; end
            default:           begin s = -ca; c = sa;  end
        endcase
    endfunction

    // rotation matrix of a rotation vector
    function automatic so3_pkg::mat_t rodrigues_matrix(so3_pkg::vec_t w_in, int unsigned lim);
        longint          w[3];
        longint          u[3];
        longint          m[9];
        longint unsigned t2;
        longint unsigned t;
        longint unsigned p;
        longint unsigned num;
        longint          s;
        longint          c;
        longint          omc;
        longint          sxy;
        longint          sxz;
        longint          syz;
        longint          one;
        so3_pkg::mat_t   res;
        t2 = 0;
        for (int i = 0; i < 3; i++)
        begin
            w[i] = longint'($signed(w_in[i]));
            t2   = t2 + mag64(w[i]) * mag64(w[i]);
        end
        t = root_floor(t2);
        if (t == 0 || t < lim)
        begin
            // first-order form, identity plus skew
            one  = fix_rescale(longint'(1) << 30, 30, so3_pkg::IN_FRAC_BITS);
            m[0] = one;   m[1] = -w[2]; m[2] = w[1];
            m[3] = w[2];  m[4] = one;   m[5] = -w[0];
            m[6] = -w[1]; m[7] = w[0];  m[8] = one;
            for (int i = 0; i < 9; i++)
            begin
                m[i] = clamp_unit(fix_rescale(m[i], so3_pkg::IN_FRAC_BITS,
                                              so3_pkg::OUT_FRAC_BITS));
            end
        end
        else
        begin
            p = ((t * so3_pkg::TURN_SCALE) >> so3_pkg::IN_FRAC_BITS) & 64'hFFFFFFFF;
            for (int i = 0; i < 3; i++)
            begin
                num  = mag64(w[i]) << 30;
                u[i] = longint'((num + (t >> 1)) / t);
                if (w[i] < 0)
                begin
                    u[i] = -u[i];
                end
            end
            phase_sincos(p, s, c);
            omc  = (longint'(1) << 30) - c;
            sxy  = fix_mul(omc, fix_mul(u[0], u[1]));
            sxz  = fix_mul(omc, fix_mul(u[0], u[2]));
            syz  = fix_mul(omc, fix_mul(u[1], u[2]));
            m[0] = c + fix_mul(omc, fix_mul(u[0], u[0]));
            m[1] = sxy - fix_mul(s, u[2]);
            m[2] = sxz + fix_mul(s, u[1]);
            m[3] = sxy + fix_mul(s, u[2]);
            m[4] = c + fix_mul(omc, fix_mul(u[1], u[1]));
            m[5] = syz - fix_mul(s, u[0]);
            m[6] = sxz - fix_mul(s, u[1]);
            m[7] = syz + fix_mul(s, u[0]);
            m[8] = c + fix_mul(omc, fix_mul(u[2], u[2]));
            for (int i = 0; i < 9; i++)
            begin
                m[i] = clamp_unit(fix_rescale(m[i], 30, so3_pkg::OUT_FRAC_BITS));
            end
        end
        for (int i = 0; i < 9; i++)
        begin
            res[i] = m[i][31:0];
        end
        return res;
    endfunction

    function automatic logic [31:0] rand_span(int span);
        return 32'($signed(32'($urandom_range(0, 2 * span))) - span);
    endfunction

    // random rotation vector, mostly realistic angles
    function automatic so3_pkg::vec_t rand_vec();
        so3_pkg::vec_t v;
        int            mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++)
        begin
            case (mode)
                0, 1:    v[i] = $urandom;
                2, 3, 4: v[i] = rand_span(1 << 27);
                5:       v[i] = rand_span(1 << 24);
                6, 7:    v[i] = rand_span(1 << 17);
                8:       v[i] = rand_span(40000);
                default: v[i] = (i == 0) ? $urandom : 32'd0;
            endcase
        end
        if (mode == 9)
        begin
            v = v << (32 * $urandom_range(0, 2));
        end
        return v;
    endfunction

    function automatic so3_pkg::vec_t mk_vec(int x, int y, int z);
        so3_pkg::vec_t v;
        v[0] = x;
        v[1] = y;
        v[2] = z;
        return v;
    endfunction

    task automatic push_vec(so3_pkg::vec_t v);
        pending_vecs = {pending_vecs, v};
        n_pushed++;
    endtask

    // write the small-angle limit while the pipeline is empty
    task automatic write_limit(logic [15:0] val);
        @(negedge clk);
        cfg_if.valid             <= 1'b1;
        cfg_if.small_angle_limit <= val;
        @(posedge clk);
        while (!cfg_if.ready)
        begin
            @(posedge clk);
        end
        angle_limit = val;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_accepted != n_pushed || exp_mats.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // driver: bursts of vectors with random gaps
    always @(negedge clk)
    begin
        if (rst_n && (!vec_if.valid || vec_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                vec_if.valid <= 1'b0;
            end
            else if (pending_vecs.size() > 0)
            begin
                so3_pkg::vec_t v;
                v = pending_vecs.pop_front();
                vec_if.omega_x <= v[0];
                vec_if.omega_y <= v[1];
                vec_if.omega_z <= v[2];
                vec_if.valid   <= 1'b1;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                begin
                    burst_left--;
                end
            end
            else
            begin
                vec_if.valid <= 1'b0;
            end
        end
    end

    // receiver stall pattern, redrawing a random mode whenever the low eight bits of the stall counter wrap to zero
    always @(negedge clk)
    begin
        stall_cnt = stall_cnt + 1;
        if (stall_cnt[7:0] == 0)
        begin
            stall_mode = $urandom_range(0, 3);
        end
        if (hold_off)
        begin
            mat_if.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0:       mat_if.ready <= 1'b1;
                1:       mat_if.ready <= $urandom_range(0, 1);
                2:       mat_if.ready <= ($urandom_range(0, 7) != 0);
                default: mat_if.ready <= (stall_cnt[2:0] < 3);
            endcase
        end
    end

    // monitor: check matrices, predict accepted vectors, watchdog
    always @(posedge clk)
    begin
        so3_pkg::mat_t act;
        so3_pkg::mat_t want;
        logic          busy;
        busy = 1'b0;
        vec_taken <= vec_if.valid && vec_if.ready;
        if (mat_if.valid && mat_if.ready)
        begin
            busy = 1'b1;
            act  = {mat_if.r22, mat_if.r21, mat_if.r20, mat_if.r12, mat_if.r11,
                    mat_if.r10, mat_if.r02, mat_if.r01, mat_if.r00};
            if (exp_mats.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= MAX_REPORTS)
                begin
                    $display("unexpected matrix transaction %h", act);
                end
            end
            else
            begin
                want = exp_mats.pop_front();
                for (int i = 0; i < 9; i++)
                begin
                    if (act[i] !== want[i])
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                        begin
                            $display("entry r%0d%0d: expected %h, actual %h",
                                     i / 3, i % 3, want[i], act[i]);
                        end
                    end
                end
            end
        end
        if (vec_if.valid && vec_if.ready)
        begin
            busy = 1'b1;
            exp_mats = {exp_mats, rodrigues_matrix({vec_if.omega_z, vec_if.omega_y,
                                                    vec_if.omega_x}, angle_limit)};
            n_accepted++;
        end
        idle_cycles = busy ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // long receiver hold-off so the pipeline fills and stalls its input
    initial
    begin
        hold_off = 1'b0;
        wait (n_accepted >= 150);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // stimulus and sequencing
    initial
    begin
        logic [15:0] limits[N_PHASES];
        rst_n                    = 1'b0;
        vec_if.valid             = 1'b0;
        vec_if.omega_x           = '0;
        vec_if.omega_y           = '0;
        vec_if.omega_z           = '0;
        mat_if.ready             = 1'b0;
        cfg_if.valid             = 1'b0;
        cfg_if.small_angle_limit = '0;
        angle_limit              = 1;
        n_pushed                 = 0;
        n_accepted               = 0;
        err_cnt                  = 0;
        idle_cycles              = 0;
        vec_taken                = 1'b0;
        burst_left               = 0;
        gap_left                 = 0;
        stall_cnt                = 0;
        stall_mode               = 0;
        limits[0] = 16'd1;
        limits[1] = 16'd0;
        limits[2] = 16'd65535;
        limits[3] = 16'($urandom);
        limits[4] = 16'd40000;
        limits[5] = 16'd1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph > 0)
            begin
                write_limit(limits[ph]);
            end
            // directed vectors: zero, extremes, quadrant angles, boundary
            if (ph == 0 || ph == 1)
            begin
                push_vec(mk_vec(0, 0, 0));
                push_vec(mk_vec(1, 0, 0));
                push_vec(mk_vec(3, -4, 0));
                push_vec(mk_vec(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
                push_vec(mk_vec(32'h80000000, 32'h80000000, 32'h80000000));
                push_vec(mk_vec(32'h80000000, 0, 0));
                push_vec(mk_vec(0, 32'h7FFFFFFF, 0));
                push_vec(mk_vec(0, 0, 32'h80000000));
                push_vec(mk_vec(52707179, 0, 0));
                push_vec(mk_vec(0, 26353589, 0));
                push_vec(mk_vec(0, 0, 105414357));
                push_vec(mk_vec(-79060768, 0, 0));
                push_vec(mk_vec(16777216, -16777216, 16777216));
                push_vec(mk_vec(100, -200, 300));
            end
            if (ph == 2)
            begin
                push_vec(mk_vec(0, 0, 0));
                push_vec(mk_vec(65534, 0, 0));
                push_vec(mk_vec(0, -65535, 0));
                push_vec(mk_vec(1000, -2000, 500));
                push_vec(mk_vec(-40000, 40000, -30000));
                push_vec(mk_vec(0, 0, 65536));
            end
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                push_vec(rand_vec());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
